// ===== hdl/vtqr_pkg.sv =====
package vtqr_pkg;

    // valve channels that exist on this controller
    localparam logic [3:0] CHAN_LIMIT = 4'd8;

    localparam logic [15:0] MS_PER_MINUTE     = 16'd60000;
    localparam logic [31:0] VOLUME_TIMEOUT_MS = 32'd1800000;
    localparam logic [15:0] CAL_RESET         = 16'd450;

    localparam logic [2:0] CMD_ADD   = 3'd0;
    localparam logic [2:0] CMD_TICK  = 3'd1;
    localparam logic [2:0] CMD_PULSE = 3'd2;
    localparam logic [2:0] CMD_STOP  = 3'd3;
    localparam logic [2:0] CMD_CLEAR = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_INVALID   = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_BUSY      = 3'd3;
    localparam logic [2:0] ST_NO_ACTIVE = 3'd4;

    localparam logic [1:0] RSN_DURATION = 2'd0;
    localparam logic [1:0] RSN_VOLUME   = 2'd1;
    localparam logic [1:0] RSN_TIMEOUT  = 2'd2;

    localparam logic MODE_DURATION = 1'b0;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [2:0]  channel;
        logic        mode;
        logic [15:0] amount;
        logic        fault;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic       valve_open;
        logic [2:0] valve_channel;
        logic       task_done;
        logic [1:0] done_reason;
        logic [4:0] pending_count;
        logic [4:0] removed_count;
    } rsp_t;

    // queue entry: channel, mode, amount
    typedef struct packed {
        logic [2:0]  channel;
        logic        mode;
        logic [15:0] amount;
    } task_t;

    typedef struct packed {
        logic       done;
        logic [1:0] reason;
    } judge_t;

endpackage

// ===== hdl/vtqr_judge.sv =====
module vtqr_judge
    import vtqr_pkg::*;
(
    input  logic        mode,
    input  logic [31:0] elapsed,
    input  logic [31:0] pulses,
    input  logic [31:0] target,
    output judge_t      verdict
);

    always_comb
    begin
        verdict = '0;
        if (mode == MODE_DURATION)
        begin
            verdict.done   = (elapsed >= target);
            verdict.reason = RSN_DURATION;
        end
        else if (pulses >= target)
        begin
            // volume wins over the safety timeout
            verdict.done   = 1'b1;
            verdict.reason = RSN_VOLUME;
        end
        else if (elapsed > VOLUME_TIMEOUT_MS)
        begin
            verdict.done   = 1'b1;
            verdict.reason = RSN_TIMEOUT;
        end
    end

endmodule

// ===== hdl/valve_task_queue_runner_unit.sv =====
// Valve task runner.
// Request channel (req_valid/req_ready/req_data): one command per request:
// add task, millisecond tick, flow pulse, stop active task, clear queue.
// Response channel (res_valid/res_ready/res_data): exactly one response per
// request, in request order.
// Configuration channel (cfg_valid/cfg_ready/cfg_data): flow calibration in
// pulses per liter; always ready, a write of zero is dropped. Write it only
// while no request is outstanding.
// Flow: on acceptance the request, the queue memory word at the head and
// the completion target are registered; the commit step then updates the
// state and loads the response register, which drives the response. A new
// request is taken only in the idle state, after the commit of the last one.
// A new request may be accepted while a response waits. If the response
// register is still full at commit time, the commit holds until res_ready.
// Reset: queue empty, no active task, counters zero, calibration 450.
// The queue memory itself is not cleared; only counted entries are read.
module valve_task_queue_runner_unit
    import vtqr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  req_t        req_data,
    output logic        res_valid,
    input  logic        res_ready,
    output rsp_t        res_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    localparam int ADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W  = FILL_W + 1;
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(QUEUE_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(QUEUE_DEPTH - 1);
    localparam logic [SUM_W-1:0] SUM_DEPTH = SUM_W'(QUEUE_DEPTH);

    typedef enum logic { S_IDLE, S_EXEC } state_t;

    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  head_reg, head_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic               active_reg, active_next;
    task_t              entry_reg, entry_next;
    logic [31:0]        elapsed_reg, elapsed_next;
    logic [31:0]        pulse_reg, pulse_next;
    logic [15:0]        ppl_reg;
    logic               res_valid_reg, res_valid_next;
    rsp_t               res_reg, res_next;
    req_t               req_reg;
    logic [31:0]        target_reg;
    task_t              task_rd_reg;

    task_t              task_mem [QUEUE_DEPTH];

    logic               req_fire;
    logic               commit;
    logic               mem_wr;
    logic [SUM_W-1:0]   tail_sum;
    logic [ADDR_W-1:0]  tail_addr;
    logic [15:0]        scale;
    logic [31:0]        elapsed_inc;
    judge_t             verdict;

    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign commit    = (state_reg == S_EXEC) && (!res_valid_reg || res_ready);
    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    assign tail_sum  = SUM_W'(head_reg) + SUM_W'(fill_reg);
    assign tail_addr = (tail_sum >= SUM_DEPTH) ? ADDR_W'(tail_sum - SUM_DEPTH)
                                               : ADDR_W'(tail_sum);

    assign scale       = (entry_reg.mode == MODE_DURATION) ? MS_PER_MINUTE : ppl_reg;
    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 32'd1;

    vtqr_judge u_judge (
        .mode    (entry_reg.mode),
        .elapsed (elapsed_inc),
        .pulses  (pulse_reg),
        .target  (target_reg),
        .verdict (verdict)
    );

    // queue memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            task_mem[tail_addr] <= task_t'{req_reg.channel, req_reg.mode, req_reg.amount};
        end
        if (req_fire)
        begin
            task_rd_reg <= task_mem[head_reg];
        end
    end

    // capture the request and the completion target for the active task
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            req_reg    <= req_data;
            target_reg <= 32'(entry_reg.amount) * 32'(scale);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppl_reg <= CAL_RESET;
        end
        else if (cfg_valid && cfg_data != 16'd0)
        begin
            ppl_reg <= cfg_data;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        active_next    = active_reg;
        entry_next     = entry_reg;
        elapsed_next   = elapsed_reg;
        pulse_next     = pulse_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        mem_wr         = 1'b0;

        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        if (req_fire)
        begin
            state_next = S_EXEC;
        end

        if (commit)
        begin
            state_next     = S_IDLE;
            res_valid_next = 1'b1;
            res_next       = '0;
            res_next.status = ST_OK;

            unique case (req_reg.cmd)
                CMD_ADD:
                begin
                    if ({1'b0, req_reg.channel} >= CHAN_LIMIT || req_reg.amount == 16'd0)
                    begin
                        res_next.status = ST_INVALID;
                    end
                    else if (fill_reg == FILL_MAX)
                    begin
                        res_next.status = ST_FULL;
                    end
                    else
                    begin
                        mem_wr    = 1'b1;
                        fill_next = fill_reg + 1'b1;
                    end
                end
                CMD_TICK:
                begin
                    if (active_reg)
                    begin
                        elapsed_next = elapsed_inc;
                    end
                    if (req_reg.fault)
                    begin
                        res_next.status = ST_BUSY;
                    end
                    else if (active_reg)
                    begin
                        if (verdict.done)
                        begin
                            active_next            = 1'b0;
                            res_next.valve_channel = entry_reg.channel;
                            res_next.task_done     = 1'b1;
                            res_next.done_reason   = verdict.reason;
                        end
                    end
                    else if (fill_reg != '0)
                    begin
                        // pop the head and open its valve
                        entry_next   = task_rd_reg;
                        head_next    = (head_reg == LAST_ADDR) ? '0 : head_reg + 1'b1;
                        fill_next    = fill_reg - 1'b1;
                        active_next  = 1'b1;
                        elapsed_next = '0;
                        pulse_next   = '0;
                    end
                end
                CMD_PULSE:
                begin
                    pulse_next = (pulse_reg == '1) ? pulse_reg : pulse_reg + 32'd1;
                end
                CMD_STOP:
                begin
                    if (active_reg)
                    begin
                        active_next            = 1'b0;
                        res_next.valve_channel = entry_reg.channel;
                    end
                    else
                    begin
                        res_next.status = ST_NO_ACTIVE;
                    end
                end
                CMD_CLEAR:
                begin
                    res_next.removed_count = 5'(fill_reg);
                    fill_next              = '0;
                end
                default:
                begin
                    res_next.status = ST_INVALID;
                end
            endcase

            if (active_next)
            begin
                res_next.valve_channel = entry_next.channel;
            end
            res_next.valve_open    = active_next;
            res_next.pending_count = 5'(fill_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            fill_reg      <= '0;
            active_reg    <= 1'b0;
            entry_reg     <= '0;
            elapsed_reg   <= '0;
            pulse_reg     <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            active_reg    <= active_next;
            entry_reg     <= entry_next;
            elapsed_reg   <= elapsed_next;
            pulse_reg     <= pulse_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_reg == res_next ? res_reg : res_next;
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_MAX)
        else $error("queue fill beyond depth");

    a_done_closes: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.task_done |-> !res_reg.valve_open)
        else $error("completed task left its valve open");

    a_start_pops: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(active_reg) |-> $past(fill_reg) == fill_reg + 1)
        else $error("task started without a pop");

    a_commit_responds: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> res_valid_reg && state_reg == S_IDLE)
        else $error("commit produced no response");

endmodule
